@@ hw/rtl/dimedfr_pkg.sv @@
// shared types and constants for the dime record deframer
package dimedfr_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned POS_W     = $clog2(HDR_BYTES);
	localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HDR_BYTES - 1);

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_ID      = 3'd1,
		KIND_TYPE    = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_PAD     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		kind_t       byte_kind;
		logic        field_last;
		logic        record_last;
		logic        message_last;
		logic        begin_flag;
		logic        end_flag;
		logic        chunk_flag;
		logic [12:0] id_size;
		logic [12:0] type_size;
		logic [31:0] payload_size;
	} out_item_t;

endpackage

@@ hw/rtl/dimedfr_stream_if.sv @@
// valid/ready stream channel carrying one item of a given type
interface dimedfr_stream_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/dimedfr_parse.sv @@
// record parse state and per-byte labelling logic
module dimedfr_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	output dimedfr_pkg::out_item_t result
);
	import dimedfr_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_ID       = 3'd1,
		PH_ID_PAD   = 3'd2,
		PH_TYPE     = 3'd3,
		PH_TYPE_PAD = 3'd4,
		PH_PAYLOAD  = 3'd5,
		PH_PAY_PAD  = 3'd6
	} phase_t;

	phase_t      phase_q, ph_next;
	logic [31:0] fpos_q, fpos_n;
	logic [23:0] hdr_q, hdr_n;
	logic [12:0] id_q, id_n, type_q, type_n;
	logic [31:0] data_q, data_n, seg_len;
	logic [2:0]  flags_q, flags_n;
	logic [POS_W-1:0] pos;
	logic        hdr_phase, flast, rlast;
	logic [6:0]  nz;
	kind_t       kind;

	// padding bytes up to the next 4-byte boundary
	function automatic logic [1:0] pad_of(input logic [1:0] len_lo);
		pad_of = 2'(~len_lo + 2'd1);
	endfunction

	// first later phase with a nonzero length, header if none
	function automatic phase_t next_ph(input phase_t cur, input logic [6:0] nzv);
		phase_t r;
		logic   found;
		r = PH_HEADER;
		found = 1'b0;
		for (int p = 1; p <= 6; p++) begin
			if (!found && 3'(p) > cur && nzv[p]) begin
				r = phase_t'(3'(p));
				found = 1'b1;
			end
		end
		return r;
	endfunction

	assign pos = fpos_q[POS_W-1:0];

	always_comb begin
		flags_n   = flags_q;
		id_n      = id_q;
		type_n    = type_q;
		data_n    = data_q;
		hdr_n     = hdr_q;
		seg_len   = '0;
		kind      = KIND_HEADER;
		hdr_phase = 1'b0;
		unique case (phase_q)
			PH_ID: begin
				seg_len = {19'd0, id_q};
				kind = KIND_ID;
			end
			PH_ID_PAD: begin
				seg_len = {30'd0, pad_of(id_q[1:0])};
				kind = KIND_PAD;
			end
			PH_TYPE: begin
				seg_len = {19'd0, type_q};
				kind = KIND_TYPE;
			end
			PH_TYPE_PAD: begin
				seg_len = {30'd0, pad_of(type_q[1:0])};
				kind = KIND_PAD;
			end
			PH_PAYLOAD: begin
				seg_len = data_q;
				kind = KIND_PAYLOAD;
			end
			PH_PAY_PAD: begin
				seg_len = {30'd0, pad_of(data_q[1:0])};
				kind = KIND_PAD;
			end
			default: hdr_phase = 1'b1;
		endcase

		if (hdr_phase) begin
			hdr_n = {hdr_q[15:0], byte_in};
			if (pos == POS_W'(0)) begin
				flags_n = byte_in[7:5];
				id_n = '0;
				type_n = '0;
				data_n = '0;
			end
			if (pos == POS_W'(1))
				id_n = {hdr_q[4:0], byte_in};
			if (pos == POS_W'(3))
				type_n = {hdr_q[4:0], byte_in};
			if (pos == HDR_LAST)
				data_n = {hdr_q, byte_in};
			flast = (pos == HDR_LAST);
		end else begin
			flast = ({1'b0, fpos_q} + 33'd1) >= {1'b0, seg_len};
		end

		nz = {data_n[1:0] != 2'd0, data_n != 32'd0, type_n[1:0] != 2'd0,
			type_n != 13'd0, id_n[1:0] != 2'd0, id_n != 13'd0, 1'b0};

		if (flast)
			ph_next = next_ph(hdr_phase ? PH_HEADER : phase_q, nz);
		else
			ph_next = hdr_phase ? PH_HEADER : phase_q;

		fpos_n = flast ? 32'd0 : fpos_q + 32'd1;
		rlast  = flast && (ph_next == PH_HEADER);

		result.byte_out     = byte_in;
		result.byte_kind    = kind;
		result.field_last   = flast;
		result.record_last  = rlast;
		result.message_last = rlast && flags_n[1];
		result.begin_flag   = flags_n[2];
		result.end_flag     = flags_n[1];
		result.chunk_flag   = flags_n[0];
		result.id_size      = id_n;
		result.type_size    = type_n;
		result.payload_size = data_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			fpos_q  <= '0;
			hdr_q   <= '0;
			id_q    <= '0;
			type_q  <= '0;
			data_q  <= '0;
			flags_q <= '0;
		end else if (step) begin
			phase_q <= ph_next;
			fpos_q  <= fpos_n;
			hdr_q   <= hdr_n;
			id_q    <= id_n;
			type_q  <= type_n;
			data_q  <= data_n;
			flags_q <= flags_n;
		end
	end

	// the header position counter never runs past the eight header bytes
	a_hdr_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> fpos_q[31:POS_W] == '0)
		else $error("header position out of range");

	// after the final byte of a record the next byte is header byte zero
	a_record_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.record_last |=> phase_q == PH_HEADER && fpos_q == 32'd0)
		else $error("record did not restart at header");

	// in a field the position stays below the field length
	a_field_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!hdr_phase |-> fpos_q < seg_len)
		else $error("field position past field length");
endmodule

@@ hw/rtl/dime_record_deframer.sv @@
// dime record deframer top level: input and result pipeline registers
//
// msg carries one message byte per item (data_byte). lbl carries one label
// item per input byte: the byte itself, its kind (header, id, type,
// payload, padding), last-of-field, last-of-record and last-of-message
// marks, and the flags and lengths of the record the byte belongs to.
// both channels use valid/ready; an item moves when both are high.
//
// an accepted byte is stored in the input register, then its label is
// computed and stored in the result register, from which the label is
// offered on lbl. one byte per cycle is sustained while lbl does not
// stall; the per-byte work is one 33-bit length compare and a
// six-way next-field search in the parse unit.
//
// when lbl stalls, the result register holds and the input register
// still takes one more byte; msg.ready drops only once both are full.
// reset marks both registers empty and puts the parser at header byte zero of
// a new message.
module dime_record_deframer (
	input logic          clk,
	input logic          arst_n,
	dimedfr_stream_if.sink   msg,
	dimedfr_stream_if.source lbl
);
	import dimedfr_pkg::*;

	logic       v_s1, v_s2;
	logic [7:0] byte_s1;
	out_item_t  res_s2, res;
	logic       s2_en, step;

	assign s2_en     = !v_s2 || lbl.ready;
	assign step      = v_s1 && s2_en;
	assign msg.ready = !v_s1 || s2_en;
	assign lbl.valid = v_s2;
	assign lbl.data  = res_s2;

	dimedfr_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (msg.ready)
				v_s1 <= msg.valid;
			if (s2_en)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid)
			byte_s1 <= msg.data.data_byte;
		if (step)
			res_s2 <= res;
	end

	// end of message only ever falls on the end of a record
	a_msg_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.message_last |-> res_s2.record_last)
		else $error("message end without record end");

	// end of a record is always the end of some field
	a_record_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.record_last |-> res_s2.field_last)
		else $error("record end without field end");

	// a byte held in the input register during a stall is not dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s2_en |=> v_s1 && $stable(byte_s1))
		else $error("input byte lost during stall");
endmodule
